// File: design/radix_integer_to_text_macros.svh
`ifndef RADIX_INTEGER_TO_TEXT_MACROS_SVH
`define RADIX_INTEGER_TO_TEXT_MACROS_SVH

// Both macros expect clk and rst_n in the scope where they are used.

`define RIT_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RIT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rit_pkg.sv
package rit_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int VALUE_BITS = 32;

    localparam int RADIX_W    = 5;
    localparam int SYM_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CHAR_W     = 8;

    localparam int DIGIT_BITS = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int MAX_DIGITS = VALUE_BITS;
    localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
    localparam int BITCNT_W   = $clog2(VALUE_BITS);
    localparam int STACK_W    = MAX_DIGITS * DIGIT_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic pop;
        logic sel_sign;
    } dp_cmd_t;

    typedef struct packed {
        logic alph_ok;
        logic neg;
        logic step_last;
        logic quot_zero;
        logic one_left;
    } dp_status_t;

endpackage

// File: design/rit_if.sv
interface rit_value_if;
    import rit_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface rit_char_if;
    import rit_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink (input valid, input out_char, input last, output ready);
endinterface

interface rit_cfg_if;
    import rit_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/radix_integer_to_text.sv
// Channel   Dir   Payload              Transfer
// in_ch     in    value                valid && ready
// out_ch    out   out_char, last       valid && ready
// cfg_ch    in    index, data          valid && ready (ready is always high)
//
// An item is accepted in S_IDLE, the bit-serial restoring divider then forms
// each digit one quotient bit at a time, and then one character per cycle is sent
// while the output is ready.
// Reset is asynchronous and clears the radix and symbols to zero.
// A stalled output holds the current character; no new input is taken meanwhile.
module radix_integer_to_text (
    input  logic       clk,
    input  logic       rst_n,
    rit_value_if.sink  in_ch,
    rit_char_if.source out_ch,
    rit_cfg_if.sink    cfg_ch
);
    import rit_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ch.ready = 1'b1;

    rit_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rit_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_ch.valid),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .value     (in_ch.value),
        .cmd       (cmd),
        .status    (status),
        .out_char  (out_ch.out_char),
        .last      (out_ch.last)
    );

endmodule

// File: design/rit_datapath.sv
module rit_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [rit_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rit_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [rit_pkg::VALUE_BITS-1:0] value,
    input  rit_pkg::dp_cmd_t                      cmd,
    output rit_pkg::dp_status_t                   status,
    output logic [rit_pkg::CHAR_W-1:0]            out_char,
    output logic                                  last
);
    import rit_pkg::*;

    logic [RADIX_W-1:0]    radix_reg;
    logic [SYM_W-1:0]      sym_lo_reg;
    logic [SYM_W-1:0]      sym_hi_reg;

    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [DIGIT_BITS-1:0] rem_reg, rem_next;
    logic [BITCNT_W-1:0]   bitcnt_reg, bitcnt_next;
    logic [STACK_W-1:0]    stack_reg, stack_next;
    logic [NDIG_W-1:0]     ndig_reg, ndig_next;
    logic                  neg_reg, neg_next;

    logic [2*SYM_W-1:0]    all_syms;
    logic [CHAR_W-1:0]     sym_arr [MAX_RADIX];
    logic                  alph_ok;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [DIGIT_BITS:0]   trial;
    logic                  trial_ge;
    logic [DIGIT_BITS-1:0] rem_step;
    logic [VALUE_BITS-1:0] quot_step;
    logic                  step_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg  <= '0;
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIX:        radix_reg  <= cfg_data[RADIX_W-1:0];
                CFG_SYMBOLS_LOW:  sym_lo_reg <= cfg_data;
                CFG_SYMBOLS_HIGH: sym_hi_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign all_syms = {sym_hi_reg, sym_lo_reg};

    always_comb
    begin
        for (int k = 0; k < MAX_RADIX; k++)
        begin
            sym_arr[k] = all_syms[k*CHAR_W +: CHAR_W];
        end
    end

    // Symbols past the radix take no part in the check.
    always_comb
    begin
        alph_ok = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            if (RADIX_W'(i) < radix_reg)
            begin
                if (sym_arr[i] == CH_NUL || sym_arr[i] == CH_PLUS || sym_arr[i] == CH_MINUS)
                begin
                    alph_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++)
                begin
                    if (RADIX_W'(j) < radix_reg && sym_arr[i] == sym_arr[j])
                    begin
                        alph_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign raw = value;
    assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

    // One bit of restoring division by the radix.
    assign trial     = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign trial_ge  = RADIX_W'(trial) >= radix_reg;
    assign rem_step  = trial_ge ? DIGIT_BITS'(RADIX_W'(trial) - radix_reg)
                                : trial[DIGIT_BITS-1:0];
    assign quot_step = {quot_reg[VALUE_BITS-2:0], trial_ge};
    assign step_last = bitcnt_reg == BITCNT_W'(VALUE_BITS - 1);

    always_comb
    begin
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        bitcnt_next = bitcnt_reg;
        stack_next  = stack_reg;
        ndig_next   = ndig_reg;
        neg_next    = neg_reg;
        if (cmd.load)
        begin
            quot_next   = mag;
            rem_next    = '0;
            bitcnt_next = '0;
            ndig_next   = '0;
            neg_next    = raw[VALUE_BITS-1];
        end
        else if (cmd.step)
        begin
            quot_next = quot_step;
            if (step_last)
            begin
                rem_next    = '0;
                bitcnt_next = '0;
                stack_next  = {stack_reg[STACK_W-DIGIT_BITS-1:0], rem_step};
                ndig_next   = ndig_reg + NDIG_W'(1);
            end
            else
            begin
                rem_next    = rem_step;
                bitcnt_next = bitcnt_reg + BITCNT_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            stack_next = stack_reg >> DIGIT_BITS;
            ndig_next  = ndig_reg - NDIG_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitcnt_reg <= '0;
            ndig_reg   <= '0;
        end
        else
        begin
            bitcnt_reg <= bitcnt_next;
            ndig_reg   <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        stack_reg <= stack_next;
        neg_reg   <= neg_next;
    end

    assign status.alph_ok   = alph_ok;
    assign status.neg       = neg_reg;
    assign status.step_last = step_last;
    assign status.quot_zero = quot_step == '0;
    assign status.one_left  = ndig_reg == NDIG_W'(1);

    assign out_char = cmd.sel_sign ? CH_MINUS : sym_arr[stack_reg[DIGIT_BITS-1:0]];
    assign last     = !cmd.sel_sign && status.one_left;

endmodule

// File: design/rit_controller.sv
`include "radix_integer_to_text_macros.svh"

module rit_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rit_pkg::dp_status_t status,
    output rit_pkg::dp_cmd_t    cmd
);
    import rit_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An item taken with a bad alphabet is dropped without any output.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.alph_ok)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.step_last && status.quot_zero)
                begin
                    state_next = status.neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_ready && status.one_left)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid && status.alph_ok;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
            end
            S_SIGN:
            begin
                out_valid    = 1'b1;
                cmd.sel_sign = 1'b1;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                cmd.pop   = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    `RIT_ASSERT_SAME(a_no_overlap, out_valid, !in_ready,
        "input taken while a character is pending")
    `RIT_ASSERT_NEXT(a_bad_alphabet_dropped, in_valid && in_ready && !status.alph_ok,
        state_reg == S_IDLE, "item with a bad alphabet was not dropped")
    `RIT_ASSERT_NEXT(a_last_ends_item,
        state_reg == S_EMIT && out_ready && status.one_left,
        state_reg == S_IDLE, "no return to idle after the last character")
    `RIT_ASSERT_SAME(a_sign_only_negative, state_reg == S_SIGN, status.neg,
        "minus sign sent for a value that is not negative")

endmodule

// File: tb/tb_radix_integer_to_text.sv
module tb_radix_integer_to_text;
    import rit_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int SETTLE_CYCLES  = 1100;
    localparam int TIMEOUT_CYCLES = 2_500_000;
    localparam int RANDOM_ITEMS   = 180;
    localparam int TEXT_W         = 8 * (MAX_DIGITS + 1);
    localparam int NUM_DIRECTED   = 41;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum bit {
        ROW_CFG,
        ROW_VALUE
    } row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [VALUE_BITS-1:0] value;
        bit                    typed;
        bit [TEXT_W-1:0]       text;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    rit_value_if in_if();
    rit_char_if  out_if();
    rit_cfg_if   cfg_if();

    radix_integer_to_text dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg_ch (cfg_if)
    );

    logic [RADIX_W-1:0] cfg_radix    = '0;
    logic [SYM_W-1:0]   cfg_sym_low  = '0;
    logic [SYM_W-1:0]   cfg_sym_high = '0;

    // Each entry holds {last, character}.
    logic [CHAR_W:0] pending_chars[$];

    int        error_count = 0;
    int        idle_pct    = 23;
    stim_row_t directed_rows[NUM_DIRECTED];

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
    begin
        out_if.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        return '{ROW_CFG, idx, data, '0, 1'b0, '0};
    endfunction

    function automatic stim_row_t value_row(input logic [VALUE_BITS-1:0] v);
        return '{ROW_VALUE, '0, '0, v, 1'b0, '0};
    endfunction

    function automatic stim_row_t text_row(input logic [VALUE_BITS-1:0] v,
                                           input bit [TEXT_W-1:0] txt);
        return '{ROW_VALUE, '0, '0, v, 1'b1, txt};
    endfunction

    function automatic bit alphabet_usable();
        logic [2*SYM_W-1:0] syms;
        int i;
        int j;
        syms = {cfg_sym_high, cfg_sym_low};
        if (cfg_radix < 2 || cfg_radix > MAX_RADIX)
            return 1'b0;
        for (i = 0; i < cfg_radix; i++)
        begin
            if (syms[8*i +: 8] == CH_NUL || syms[8*i +: 8] == CH_PLUS ||
                syms[8*i +: 8] == CH_MINUS)
                return 1'b0;
            for (j = i + 1; j < cfg_radix; j++)
            begin
                if (syms[8*j +: 8] == syms[8*i +: 8])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Queues the characters that the current alphabet makes of one value.
    function automatic void render_value(input logic [VALUE_BITS-1:0] v);
        logic [2*SYM_W-1:0]    syms;
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits[0:MAX_DIGITS-1];
        int unsigned           base;
        int                    n;
        int                    k;
        if (!alphabet_usable())
            return;
        syms = {cfg_sym_high, cfg_sym_low};
        base = 32'(cfg_radix);
        mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
        if (v[VALUE_BITS-1])
            pending_chars.push_back({1'b0, CH_MINUS});
        n = 0;
        do
        begin
            digits[n] = 4'(mag % base);
            n++;
            mag = mag / base;
        end
        while (mag != 0);
        for (k = n - 1; k >= 0; k--)
            pending_chars.push_back({k == 0, syms[8*digits[k] +: 8]});
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        int unsigned shift;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 40) - 20;
            2: v = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF) ^ $urandom_range(0, 7);
            default:
            begin
                shift = $urandom_range(0, 31);
                v = $urandom >> shift;
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [VALUE_BITS-1:0] v, input bit typed,
                              input bit [TEXT_W-1:0] txt);
        int i;
        cfg_if.valid <= 1'b0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        if (typed)
        begin
            for (i = MAX_DIGITS; i >= 0; i--)
            begin
                if (txt[8*i +: 8] != CH_NUL)
                    pending_chars.push_back({i == 0, txt[8*i +: 8]});
            end
        end
        else
            render_value(v);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cfg_if.valid <= 1'b0;
            @(negedge clk);
        end
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            CFG_RADIX:        cfg_radix    = data[RADIX_W-1:0];
            CFG_SYMBOLS_LOW:  cfg_sym_low  = data;
            CFG_SYMBOLS_HIGH: cfg_sym_high = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // An invalid alphabet yields no characters, so the block may still be busy
    // after the last expected character; the settle time covers that.
    task automatic wait_for_quiet();
        in_if.valid  <= 1'b0;
        cfg_if.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        logic [CHAR_W:0] want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                         $time, out_if.out_char, out_if.last);
                error_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_if.out_char !== want[CHAR_W-1:0])
                begin
                    $display("%0t: out_char mismatch, expected %h, actual %h",
                             $time, want[CHAR_W-1:0], out_if.out_char);
                    error_count++;
                end
                if (out_if.last !== want[CHAR_W])
                begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, want[CHAR_W], out_if.last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [2*SYM_W-1:0]    syms;
        logic [VALUE_BITS-1:0] v;
        logic [7:0]            sym;
        bit [255:0]            taken;
        int unsigned           next_radix;
        int                    pos;
        int                    r;
        int                    i;
        int                    phase;
        int                    n_items;
        int                    sent_items;
        bit                    items_since_cfg;

        in_if.valid  = 1'b0;
        in_if.value  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
        rst_n        = 1'b0;

        directed_rows = '{
            text_row(32'd12345, ""),
            text_row(-32'sd1, ""),
            cfg_row(CFG_SYMBOLS_LOW, "76543210"),
            cfg_row(CFG_SYMBOLS_HIGH, "98"),
            cfg_row(CFG_RADIX, 64'd1),
            text_row(32'd7, ""),
            cfg_row(CFG_RADIX, 64'd10),
            text_row(32'd0, "0"),
            text_row(-32'sd1, "-1"),
            text_row(32'h7FFF_FFFF, "2147483647"),
            text_row(32'h8000_0000, "-2147483648"),
            value_row(-32'sd305419896),
            cfg_row(CFG_RADIX, 64'd17),
            text_row(32'd5, ""),
            cfg_row(CFG_RADIX, 64'd31),
            text_row(-32'sd5, ""),
            cfg_row(CFG_SYMBOLS_HIGH, "FEDCBA98"),
            cfg_row(CFG_RADIX, 64'd16),
            text_row(32'h7FFF_FFFF, "7FFFFFFF"),
            text_row(32'h8000_0000, "-80000000"),
            text_row(-32'sd255, "-FF"),
            value_row(32'h1234_5678),
            cfg_row(CFG_RADIX, 64'd2),
            text_row(-32'sd1, "-1"),
            value_row(32'h8000_0000),
            value_row(32'h7FFF_FFFF),
            cfg_row(CFG_UNUSED, '1),
            text_row(32'd5, "101"),
            cfg_row(CFG_RADIX, 64'd3),
            cfg_row(CFG_SYMBOLS_LOW, {"76543", CH_NUL, "10"}),
            text_row(32'd8, ""),
            cfg_row(CFG_SYMBOLS_LOW, "76543+10"),
            text_row(32'd8, ""),
            cfg_row(CFG_SYMBOLS_LOW, "76543-10"),
            text_row(32'd8, ""),
            cfg_row(CFG_SYMBOLS_LOW, "76543010"),
            text_row(32'd8, ""),
            cfg_row(CFG_RADIX, 64'd2),
            text_row(-32'sd6, "-110"),
            cfg_row(CFG_SYMBOLS_LOW, '1),
            text_row(32'd1, "")
        };

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        items_since_cfg = 1'b0;
        for (r = 0; r < NUM_DIRECTED; r++)
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                if (items_since_cfg)
                    wait_for_quiet();
                items_since_cfg = 1'b0;
                write_reg(directed_rows[r].index, directed_rows[r].data);
            end
            else
            begin
                items_since_cfg = 1'b1;
                send_value(directed_rows[r].value, directed_rows[r].typed,
                           directed_rows[r].text);
            end
        end

        phase = 0;
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            wait_for_quiet();
            idle_pct = (phase == 1) ? 0 : 23;

            syms = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 3))
                0: next_radix = 2;
                1: next_radix = MAX_RADIX;
                2: next_radix = 10;
                default: next_radix = $urandom_range(3, MAX_RADIX - 1);
            endcase
            taken = '0;
            for (i = 0; i < next_radix; i++)
            begin
                do
                    sym = 8'($urandom_range(1, 255));
                while (sym == CH_PLUS || sym == CH_MINUS || taken[sym]);
                taken[sym] = 1'b1;
                syms[8*i +: 8] = sym;
            end
            if ($urandom_range(0, 9) >= 8)
            begin
                pos = $urandom_range(0, next_radix - 1);
                case ($urandom_range(0, 4))
                    0: next_radix = $urandom_range(0, 1);
                    1: next_radix = $urandom_range(MAX_RADIX + 1, 31);
                    2: syms[8*pos +: 8] = CH_NUL;
                    3: syms[8*pos +: 8] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                    default: syms[8*pos +: 8] = syms[8*((pos + 1) % next_radix) +: 8];
                endcase
            end

            if (phase == 0 || $urandom_range(0, 5) != 0)
                write_reg(CFG_SYMBOLS_LOW, syms[SYM_W-1:0]);
            if (phase == 0 || $urandom_range(0, 5) != 0)
                write_reg(CFG_SYMBOLS_HIGH, syms[2*SYM_W-1:SYM_W]);
            write_reg(CFG_RADIX, 64'(next_radix));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, {$urandom, $urandom});

            n_items = $urandom_range(10, 30);
            repeat (n_items)
            begin
                v = random_value();
                sent_items++;
                send_value(v, 1'b0, '0);
            end
            phase++;
        end

        wait_for_quiet();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
